// ----- rtl/s2h_pkg.sv -----
// ----------------------------------------------------------------------------
// s2h_pkg: shared types and constants of the sensor to HID report mapper
// Holds operation, target and combine codes, the queue entry layout and the
// fixed-point constants used by the front and back parts.
// ----------------------------------------------------------------------------
package s2h_pkg;

  localparam int FRAC_BITS = 8;
  localparam int KEY_SLOTS = 6;
  localparam int AXIS_COUNT = 6;
  localparam int VAL_W = 52;
  localparam int DIFF_W = 25;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CNT_W = $clog2(PROD_W);

  localparam logic signed [VAL_W-1:0] FRAC_MASK = VAL_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [VAL_W-1:0] FIX_ONE = VAL_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    OP_AXIS   = 2'd0,
    OP_THRESH = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [3:0] TGT_KEY   = 4'd0;
  localparam logic [3:0] TGT_LX    = 4'd1;
  localparam logic [3:0] TGT_LY    = 4'd2;
  localparam logic [3:0] TGT_RX    = 4'd3;
  localparam logic [3:0] TGT_RY    = 4'd4;
  localparam logic [3:0] TGT_LT    = 4'd5;
  localparam logic [3:0] TGT_RT    = 4'd6;
  localparam logic [3:0] TGT_PAD   = 4'd7;
  localparam logic [3:0] TGT_MX    = 4'd8;
  localparam logic [3:0] TGT_MY    = 4'd9;
  localparam logic [3:0] TGT_MBTN  = 4'd10;
  localparam logic [3:0] TGT_WHEEL = 4'd11;

  localparam logic [1:0] CMB_ADD_POS = 2'd1;
  localparam logic [1:0] CMB_ADD_NEG = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIX,
    ST_APPLY
  } back_state_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [3:0]               target;
    logic [1:0]               combine;
    logic                     clamp;
    logic [7:0]               keycode;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] den;
    logic                     den_zero;
    logic signed [23:0]       c;
    logic signed [23:0]       d;
    logic                     trig;
  } entry_t;

endpackage

// ----- rtl/s2h_if.sv -----
// ----------------------------------------------------------------------------
// s2h_if: channel interfaces of the sensor to HID report mapper
// One interface for mapping requests and one for report results, each with
// valid/ready handshake and the payload fields.
// ----------------------------------------------------------------------------
interface s2h_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [23:0] sample;
  logic [3:0]         target;
  logic [1:0]         combine;
  logic signed [23:0] param_a;
  logic signed [23:0] param_b;
  logic signed [23:0] param_c;
  logic signed [23:0] param_d;
  logic               clamp_enable;
  logic [7:0]         keycode;

  modport source (output valid, operation, sample, target, combine, param_a, param_b,
                  param_c, param_d, clamp_enable, keycode, input ready);
  modport sink (input valid, operation, sample, target, combine, param_a, param_b,
                param_c, param_d, clamp_enable, keycode, output ready);
endinterface

interface s2h_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         written_target;
  logic signed [15:0] axis_value;
  logic [47:0]        key_slots_packed;
  logic [31:0]        gamepad_buttons;
  logic [7:0]         mouse_buttons;
  logic signed [7:0]  mouse_dx;
  logic signed [7:0]  mouse_dy;
  logic signed [7:0]  wheel_delta;
  logic               drive_level;

  modport source (output valid, written_target, axis_value, key_slots_packed,
                  gamepad_buttons, mouse_buttons, mouse_dx, mouse_dy, wheel_delta,
                  drive_level, input ready);
  modport sink (input valid, written_target, axis_value, key_slots_packed,
                gamepad_buttons, mouse_buttons, mouse_dx, mouse_dy, wheel_delta,
                drive_level, output ready);
endinterface

// ----- rtl/s2h_front.sv -----
// ----------------------------------------------------------------------------
// s2h_front: request intake
// Accepts mapping requests, evaluates the threshold test and the operand
// differences, and hands a classified entry to the queue.
// ----------------------------------------------------------------------------
module s2h_front (
  s2h_in_if.sink          sensor_in,
  input  logic            full,
  output logic            push,
  output s2h_pkg::entry_t entry
);

  logic signed [24:0] x_ext;
  logic signed [24:0] a_ext;
  logic signed [24:0] b_ext;
  logic signed [24:0] c_ext;
  logic signed [24:0] d_ext;
  logic signed [24:0] mag;

  assign sensor_in.ready = !full;
  assign push = sensor_in.valid && !full;

  assign x_ext = {sensor_in.sample[23], sensor_in.sample};
  assign a_ext = {sensor_in.param_a[23], sensor_in.param_a};
  assign b_ext = {sensor_in.param_b[23], sensor_in.param_b};
  assign c_ext = {sensor_in.param_c[23], sensor_in.param_c};
  assign d_ext = {sensor_in.param_d[23], sensor_in.param_d};
  assign mag = x_ext[24] ? -x_ext : x_ext;

  always_comb begin
    entry.op = sensor_in.operation;
    entry.target = sensor_in.target;
    entry.combine = sensor_in.combine;
    entry.clamp = sensor_in.clamp_enable;
    entry.keycode = sensor_in.keycode;
    entry.dx = x_ext - a_ext;
    entry.dy = d_ext - c_ext;
    entry.den = b_ext - a_ext;
    entry.den_zero = (sensor_in.param_a == sensor_in.param_b);
    entry.c = sensor_in.param_c;
    entry.d = sensor_in.param_d;
    entry.trig = (x_ext > a_ext) || (x_ext < -b_ext) || (mag > c_ext);
  end

endmodule

// ----- rtl/s2h_queue.sv -----
// ----------------------------------------------------------------------------
// s2h_queue: two-entry request queue
// Decouples intake from the arithmetic back part so each side stalls alone.
// ----------------------------------------------------------------------------
module s2h_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  s2h_pkg::entry_t push_entry,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output s2h_pkg::entry_t pop_entry
);

  s2h_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

// ----- rtl/s2h_back.sv -----
// ----------------------------------------------------------------------------
// s2h_back: mapping execution and report state
// Runs the rescale for axis mappings (multiply, bit-serial divide, offset and
// clamp), then applies the value to the HID report and registers the result.
// ----------------------------------------------------------------------------
module s2h_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  s2h_pkg::entry_t q_entry,
  output logic            pop,
  s2h_out_if.source       report_out
);

  localparam int VW = s2h_pkg::VAL_W;
  localparam int DW = s2h_pkg::DIFF_W;
  localparam int PW = s2h_pkg::PROD_W;
  localparam int CW = s2h_pkg::CNT_W;

  s2h_pkg::back_state_t state;
  s2h_pkg::back_state_t state_next;
  s2h_pkg::entry_t      ent;

  logic signed [VW-1:0] val;
  logic signed [VW-1:0] val_init;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        quo;
  logic [DW-1:0]        rem;
  logic [DW-1:0]        dvs;
  logic                 neg;
  logic [CW-1:0]        cnt;
  logic [DW:0]          trial;
  logic signed [VW-1:0] q_signed;
  logic signed [VW-1:0] v_off;
  logic signed [VW-1:0] lo;
  logic signed [VW-1:0] hi;
  logic signed [VW-1:0] v_fix;

  logic do_take, do_mul, do_load, do_div, do_fix, do_apply;

  logic [7:0]         key_slot [s2h_pkg::KEY_SLOTS];
  logic signed [15:0] axis_store [s2h_pkg::AXIS_COUNT];
  logic [31:0]        pad_bits;
  logic [7:0]         mbtn_bits;
  logic signed [7:0]  mx_store;
  logic signed [7:0]  my_store;
  logic signed [7:0]  wheel_store;

  logic [7:0]         key_slot_next [s2h_pkg::KEY_SLOTS];
  logic signed [15:0] axis_store_next [s2h_pkg::AXIS_COUNT];
  logic [31:0]        pad_bits_next;
  logic [7:0]         mbtn_bits_next;
  logic signed [7:0]  mx_store_next;
  logic signed [7:0]  my_store_next;
  logic signed [7:0]  wheel_store_next;
  logic [3:0]         wt_next;
  logic signed [15:0] axv_next;
  logic               drive_next;
  logic [47:0]        packed_next;

  logic               out_valid;
  logic [3:0]         out_wt;
  logic signed [15:0] out_axv;
  logic [47:0]        out_packed;
  logic [31:0]        out_pad;
  logic [7:0]         out_mbtn;
  logic signed [7:0]  out_mx;
  logic signed [7:0]  out_my;
  logic signed [7:0]  out_wheel;
  logic               out_drive;

  // Integer part truncated toward zero.
  function automatic logic signed [VW-1:0] trunc_frac(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] biased;
    biased = v[VW-1] ? v + s2h_pkg::FRAC_MASK : v;
    return biased >>> s2h_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
    logic signed [15:0] r;
    if (v > VW'(32767)) r = 16'sd32767;
    else if (v < -VW'(32768)) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [7:0] sat8(input logic signed [VW-1:0] v);
    logic signed [7:0] r;
    if (v > VW'(127)) r = 8'sd127;
    else if (v < -VW'(128)) r = -8'sd128;
    else r = v[7:0];
    return r;
  endfunction

  // ---------------- control ----------------
  always_comb begin
    do_take = 1'b0;
    do_mul = 1'b0;
    do_load = 1'b0;
    do_div = 1'b0;
    do_fix = 1'b0;
    do_apply = 1'b0;
    case (state)
      s2h_pkg::ST_IDLE:  do_take = q_valid;
      s2h_pkg::ST_MUL:   do_mul = 1'b1;
      s2h_pkg::ST_LOAD:  do_load = 1'b1;
      s2h_pkg::ST_DIV:   do_div = 1'b1;
      s2h_pkg::ST_FIX:   do_fix = 1'b1;
      s2h_pkg::ST_APPLY: do_apply = !out_valid || report_out.ready;
      default: ;
    endcase
  end

  assign pop = do_take;

  always_comb begin
    state_next = state;
    case (state)
      s2h_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_entry.op == s2h_pkg::OP_AXIS && !q_entry.den_zero) begin
            state_next = s2h_pkg::ST_MUL;
          end else begin
            state_next = s2h_pkg::ST_APPLY;
          end
        end
      end
      s2h_pkg::ST_MUL:  state_next = s2h_pkg::ST_LOAD;
      s2h_pkg::ST_LOAD: state_next = s2h_pkg::ST_DIV;
      s2h_pkg::ST_DIV: begin
        if (cnt == CW'(PW - 1)) state_next = s2h_pkg::ST_FIX;
      end
      s2h_pkg::ST_FIX: state_next = s2h_pkg::ST_APPLY;
      s2h_pkg::ST_APPLY: begin
        if (do_apply) state_next = s2h_pkg::ST_IDLE;
      end
      default: state_next = s2h_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= s2h_pkg::ST_IDLE;
    else state <= state_next;
  end

  // ---------------- arithmetic ----------------
  always_comb begin
    val_init = '0;
    if (q_entry.op == s2h_pkg::OP_AXIS) begin
      val_init = VW'(q_entry.c);
    end else if (q_entry.op == s2h_pkg::OP_THRESH && q_entry.trig) begin
      val_init = s2h_pkg::FIX_ONE;
    end
  end

  assign trial = {rem, quo[PW-1]} - {1'b0, dvs};
  assign q_signed = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign v_off = q_signed + VW'(ent.c);
  assign lo = ent.dy[DW-1] ? VW'(ent.d) : VW'(ent.c);
  assign hi = ent.dy[DW-1] ? VW'(ent.c) : VW'(ent.d);

  always_comb begin
    v_fix = v_off;
    if (ent.clamp) begin
      if (v_off < lo) v_fix = lo;
      else if (v_off > hi) v_fix = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (do_take) begin
      ent <= q_entry;
      val <= val_init;
    end
    if (do_mul) prod <= ent.dx * ent.dy;
    if (do_load) begin
      quo <= prod[PW-1] ? PW'(-prod) : PW'(prod);
      dvs <= ent.den[DW-1] ? DW'(-ent.den) : DW'(ent.den);
      rem <= '0;
      neg <= prod[PW-1] ^ ent.den[DW-1];
      cnt <= '0;
    end
    if (do_div) begin
      // Restoring division, one quotient bit per cycle.
      if (!trial[DW]) rem <= trial[DW-1:0];
      else rem <= {rem[DW-2:0], quo[PW-1]};
      quo <= {quo[PW-2:0], !trial[DW]};
      cnt <= cnt + CW'(1);
    end
    if (do_fix) val <= v_fix;
  end

  // ---------------- report update ----------------
  always_comb begin
    logic signed [VW-1:0] ip;
    logic signed [VW-1:0] ip_pos;
    logic signed [VW-1:0] ip_neg;
    logic signed [16:0]   sum;
    logic signed [15:0]   addend;
    logic [2:0]           k;
    logic                 found;
    logic                 high;

    ip = trunc_frac(val);
    ip_pos = val > 0 ? ip : '0;
    ip_neg = val < 0 ? ip : '0;
    high = (val <<< 1) > s2h_pkg::FIX_ONE;
    k = ent.target[2:0] - 3'd1;
    addend = (ent.combine == s2h_pkg::CMB_ADD_POS) ? sat16(ip_pos) : sat16(ip_neg);
    sum = 17'(axis_store[k]) + 17'(addend);
    found = 1'b0;

    key_slot_next = key_slot;
    axis_store_next = axis_store;
    pad_bits_next = pad_bits;
    mbtn_bits_next = mbtn_bits;
    mx_store_next = mx_store;
    my_store_next = my_store;
    wheel_store_next = wheel_store;
    wt_next = '0;
    axv_next = '0;
    drive_next = 1'b0;

    if (ent.op == s2h_pkg::OP_CLEAR) begin
      for (int i = 0; i < s2h_pkg::KEY_SLOTS; i++) key_slot_next[i] = '0;
      for (int i = 0; i < s2h_pkg::AXIS_COUNT; i++) axis_store_next[i] = '0;
      pad_bits_next = '0;
      mbtn_bits_next = '0;
      mx_store_next = '0;
      my_store_next = '0;
      wheel_store_next = '0;
    end else if (ent.op == s2h_pkg::OP_AXIS || ent.op == s2h_pkg::OP_THRESH) begin
      wt_next = ent.target;
      drive_next = high;
      if (ent.target == s2h_pkg::TGT_KEY) begin
        // Axis mappings never change a key slot; only threshold mappings do.
        for (int i = 0; i < s2h_pkg::KEY_SLOTS; i++) begin
          if (!found && ent.op == s2h_pkg::OP_THRESH) begin
            if (high && (key_slot[i] == ent.keycode || key_slot[i] == 8'd0)) begin
              key_slot_next[i] = ent.keycode;
              found = 1'b1;
            end else if (!high && key_slot[i] == ent.keycode) begin
              key_slot_next[i] = 8'd0;
              found = 1'b1;
            end
          end
        end
      end else if (ent.target >= s2h_pkg::TGT_LX && ent.target <= s2h_pkg::TGT_RT) begin
        if (ent.combine == s2h_pkg::CMB_ADD_POS || ent.combine == s2h_pkg::CMB_ADD_NEG) begin
          axv_next = sat16(VW'(sum));
        end else begin
          axv_next = sat16(ip);
        end
        axis_store_next[k] = axv_next;
      end else if (ent.target == s2h_pkg::TGT_PAD) begin
        if (ent.op == s2h_pkg::OP_THRESH && ent.keycode < 8'd32) begin
          pad_bits_next[ent.keycode[4:0]] = high;
        end else if (ent.op == s2h_pkg::OP_AXIS) begin
          pad_bits_next[0] = high;
        end
      end else if (ent.target == s2h_pkg::TGT_MX) begin
        mx_store_next = sat8(ip);
      end else if (ent.target == s2h_pkg::TGT_MY) begin
        my_store_next = sat8(ip);
      end else if (ent.target == s2h_pkg::TGT_MBTN) begin
        if (ent.op == s2h_pkg::OP_THRESH && ent.keycode < 8'd8) begin
          mbtn_bits_next[ent.keycode[2:0]] = high;
        end else if (ent.op == s2h_pkg::OP_AXIS) begin
          mbtn_bits_next[0] = high;
        end
      end else if (ent.target == s2h_pkg::TGT_WHEEL) begin
        wheel_store_next = sat8(ip);
      end
    end

    for (int i = 0; i < s2h_pkg::KEY_SLOTS; i++) packed_next[8*i +: 8] = key_slot_next[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < s2h_pkg::KEY_SLOTS; i++) key_slot[i] <= '0;
      for (int i = 0; i < s2h_pkg::AXIS_COUNT; i++) axis_store[i] <= '0;
      pad_bits <= '0;
      mbtn_bits <= '0;
      mx_store <= '0;
      my_store <= '0;
      wheel_store <= '0;
    end else if (do_apply) begin
      key_slot <= key_slot_next;
      axis_store <= axis_store_next;
      pad_bits <= pad_bits_next;
      mbtn_bits <= mbtn_bits_next;
      mx_store <= mx_store_next;
      my_store <= my_store_next;
      wheel_store <= wheel_store_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_apply) begin
      out_valid <= 1'b1;
    end else if (report_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_apply) begin
      out_wt <= wt_next;
      out_axv <= axv_next;
      out_packed <= packed_next;
      out_pad <= pad_bits_next;
      out_mbtn <= mbtn_bits_next;
      out_mx <= mx_store_next;
      out_my <= my_store_next;
      out_wheel <= wheel_store_next;
      out_drive <= drive_next;
    end
  end

  assign report_out.valid = out_valid;
  assign report_out.written_target = out_wt;
  assign report_out.axis_value = out_axv;
  assign report_out.key_slots_packed = out_packed;
  assign report_out.gamepad_buttons = out_pad;
  assign report_out.mouse_buttons = out_mbtn;
  assign report_out.mouse_dx = out_mx;
  assign report_out.mouse_dy = out_my;
  assign report_out.wheel_delta = out_wheel;
  assign report_out.drive_level = out_drive;

endmodule

// ----- rtl/sensor_to_hid_report_mapper_top.sv -----
// ----------------------------------------------------------------------------
// sensor_to_hid_report_mapper_top: sensor sample to HID report mapper
// Applies axis or threshold mappings to fixed-point samples and keeps the
// resulting HID report, returning one report snapshot per request.
// ----------------------------------------------------------------------------
// Each request produces exactly one result. An axis mapping with distinct input
// bounds passes from queue to result register through a multiply step, a load
// step, a 50-step bit-serial divider that retires one quotient bit per cycle,
// an offset/clamp step and the report update. Threshold, clear and axis
// mappings with equal input bounds go straight to the report update. A
// two-entry queue sits behind the intake, so up to two further requests are
// taken while one is being worked on; a finished result waits in its own register.
module sensor_to_hid_report_mapper_top (
  input  logic       clk,
  input  logic       rst,
  s2h_in_if.sink     sensor_in,
  s2h_out_if.source  report_out
);

  logic            push;
  logic            full;
  logic            q_valid;
  logic            pop;
  s2h_pkg::entry_t push_entry;
  s2h_pkg::entry_t q_entry;

  s2h_front u_front (
    .sensor_in (sensor_in),
    .full      (full),
    .push      (push),
    .entry     (push_entry)
  );

  s2h_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop_valid  (q_valid),
    .pop        (pop),
    .pop_entry  (q_entry)
  );

  s2h_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .report_out (report_out)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_transfer_fills_queue: assert property (@(posedge clk) disable iff (rst)
    sensor_in.valid && sensor_in.ready |=> q_valid)
    else $error("accepted request missing from queue");

  a_axis_value_only_on_axes: assert property (@(posedge clk) disable iff (rst)
    report_out.valid && (report_out.written_target == s2h_pkg::TGT_KEY ||
                         report_out.written_target > s2h_pkg::TGT_RT)
    |-> report_out.axis_value == 16'sd0)
    else $error("axis value reported for a non-axis target");

endmodule
